// ===== rtl/core/bayer_dm_pkg.sv =====
// shared types, codes and constants for the gbrg bilinear demosaic
package bayer_dm_pkg;

	localparam int CFG_ADDR_W       = 2;
	localparam int CFG_DATA_W       = 13;
	localparam int SIZE_MIN         = 2;
	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;

	localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_DRAIN  = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
		logic       run_last;
	} out_item_t;

	typedef enum logic [1:0] {
		PIX_SAMP1,
		PIX_SAMP2,
		PIX_DRAIN
	} pix_mode_t;

	typedef enum logic [1:0] {
		RD_COL,
		RD_DC_M1,
		RD_DC_0,
		RD_DC_P1
	} rd_sel_t;

	typedef enum logic [1:0] {
		WIN_HOLD,
		WIN_SAMPLE,
		WIN_DRAIN,
		WIN_ZERO
	} win_op_t;

	typedef struct packed {
		logic      take;
		logic      wr_en;
		rd_sel_t   rd_sel;
		win_op_t   win_op;
		logic      calc;
		pix_mode_t mode;
		logic      load;
		logic      run_last;
		logic      adv_samp;
		logic      adv_drain;
	} dp_cmd_t;

	typedef struct packed {
		logic draining;
		logic pix1;
		logic pix2;
	} dp_stat_t;

endpackage

// ===== rtl/core/bayer_gbrg_bilinear_demosaic.sv =====
// top level: gbrg bayer to rgb bilinear demosaic
// in channel: in_valid/in_ready carry in_data, a raster bayer sample
//   (req_type sample) or a drain step (req_type drain) after the last sample
// out channel: out_valid/out_ready carry out_data, one rgb pixel per transfer;
//   run_last marks the last pixel of an input item, frame_end the last of a frame
// cfg channel: cfg_valid/cfg_ready write frame_width (index 0) or frame_height
//   (index 1); cfg_ready is always high, write only while the block is idle
// steps: an item is taken only in idle; an ignored one ends there, a sample shifts
//   the window, then sums and loads each pixel, and a drain step fills the window
//   in its drain states, then sums and loads its pixel; the order is set by the single
//   window unit stepped by the sequencer and the registered line memory read
// pixels lag the samples by one row plus one pixel; drain steps emit the last row
// reset: counters cleared, size 640 x 480, line memories hold whatever they held
// stall: one output register; the next item is taken while a pixel waits, and
//   the block stops before loading another until the waiting one is transferred
module bayer_gbrg_bilinear_demosaic import bayer_dm_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	bayer_dm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (in_data.req_type),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bayer_dm_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/core/bayer_dm_ram.sv =====
// generic single-write, single-read ram with registered read data
module bayer_dm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read-first: a read and a write at one address return the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/bayer_dm_dp.sv =====
// datapath: size registers, position counters, line memories, window and pixel unit
module bayer_dm_dp import bayer_dm_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  in_item_t              in_data,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output out_item_t             out_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int SWW = $clog2(MAX_WIDTH + 1);
	localparam int SHW = $clog2(MAX_HEIGHT + 1);
	localparam int WX  = SWW + 1;
	localparam int HX  = SHW + 1;

	localparam logic [SWW-1:0] W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ?
		SWW'(MAX_WIDTH) : SWW'(FRAME_WIDTH_RST);
	localparam logic [SHW-1:0] H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ?
		SHW'(MAX_HEIGHT) : SHW'(FRAME_HEIGHT_RST);

	typedef enum logic [1:0] {
		CLR_RED,
		CLR_GREEN,
		CLR_BLUE
	} colour_t;

	function automatic colour_t site_colour(input logic row_odd, input logic col_odd);
		if (!row_odd) begin
			site_colour = col_odd ? CLR_BLUE : CLR_GREEN;
		end else begin
			site_colour = col_odd ? CLR_GREEN : CLR_RED;
		end
	endfunction

	// floor of sum over count; thirds by reciprocal 683/2048, exact below 1024
	function automatic logic [7:0] mean_of(input logic [10:0] s, input logic [2:0] n);
		logic [21:0] p;
		p = 22'(s) * 22'd683;
		case (n)
			3'd1:    mean_of = s[7:0];
			3'd2:    mean_of = s[8:1];
			3'd3:    mean_of = p[18:11];
			3'd4:    mean_of = s[9:2];
			default: mean_of = 8'd0;
		endcase
	endfunction

	logic [SWW-1:0] w_q;
	logic [SHW-1:0] h_q;
	logic [SWW-1:0] w_wr;
	logic [SHW-1:0] h_wr;
	logic [RW-1:0]  r_q;
	logic [CW-1:0]  c_q;
	logic [CW-1:0]  dc_q;
	logic           draining_q;
	logic [7:0]     sample_q;
	logic [7:0]     win_q [3][3];
	logic [7:0]     col_new [3];
	logic [CW-1:0]  raddr;
	logic [7:0]     rd_even;
	logic [7:0]     rd_odd;
	logic [7:0]     same_d;
	logic [7:0]     other_d;
	logic           row_end;
	logic           last_row;
	logic           drain_last;
	logic [RW-1:0]  pr;
	logic [CW-1:0]  pc;
	logic [SHW-1:0] rows;
	logic [HX-1:0]  prx;
	logic [WX-1:0]  pcx;
	logic [2:0]     rv;
	logic [2:0]     cv;
	logic [10:0]    sum_r;
	logic [10:0]    sum_g;
	logic [10:0]    sum_b;
	logic [2:0]     cnt_r;
	logic [2:0]     cnt_g;
	logic [2:0]     cnt_b;
	colour_t        own;
	logic [10:0]    sum_r_s1;
	logic [10:0]    sum_g_s1;
	logic [10:0]    sum_b_s1;
	logic [2:0]     cnt_r_s1;
	logic [2:0]     cnt_g_s1;
	logic [2:0]     cnt_b_s1;
	colour_t        own_s1;
	logic [7:0]     ctr_s1;
	out_item_t      out_q;

	// size registers, clamped on write
	always_comb begin
		if (cfg_data < CFG_DATA_W'(SIZE_MIN)) begin
			w_wr = SWW'(SIZE_MIN);
			h_wr = SHW'(SIZE_MIN);
		end else begin
			w_wr = (32'(cfg_data) > MAX_WIDTH)  ? SWW'(MAX_WIDTH)  : SWW'(cfg_data);
			h_wr = (32'(cfg_data) > MAX_HEIGHT) ? SHW'(MAX_HEIGHT) : SHW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= W_RST;
			h_q <= H_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  w_q <= w_wr;
				CFG_FRAME_HEIGHT: h_q <= h_wr;
				default: ;
			endcase
		end
	end

	// position counters
	assign row_end    = SWW'(c_q) >= (w_q - 1'b1);
	assign last_row   = SHW'(r_q) >= (h_q - 1'b1);
	assign drain_last = SWW'(dc_q) >= (w_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q        <= '0;
			c_q        <= '0;
			dc_q       <= '0;
			draining_q <= 1'b0;
		end else if (cmd.adv_samp) begin
			if (row_end) begin
				c_q <= '0;
				if (last_row) begin
					draining_q <= 1'b1;
					dc_q       <= '0;
				end else begin
					r_q <= r_q + 1'b1;
				end
			end else begin
				c_q <= c_q + 1'b1;
			end
		end else if (cmd.adv_drain) begin
			if (drain_last) begin
				draining_q <= 1'b0;
				dc_q       <= '0;
				r_q        <= '0;
				c_q        <= '0;
			end else begin
				dc_q <= dc_q + 1'b1;
			end
		end
	end

	assign stat.draining = draining_q;
	assign stat.pix1     = (r_q != '0) && (c_q != '0);
	assign stat.pix2     = (r_q != '0) && row_end;

	// line memories, one per row parity
	always_comb begin
		case (cmd.rd_sel)
			RD_COL:   raddr = c_q;
			RD_DC_M1: raddr = dc_q - 1'b1;
			RD_DC_0:  raddr = dc_q;
			RD_DC_P1: raddr = dc_q + 1'b1;
			default:  raddr = c_q;
		endcase
	end

	bayer_dm_ram #(
		.WIDTH (8),
		.DEPTH (MAX_WIDTH)
	) u_line_even (
		.clk   (clk),
		.we    (cmd.wr_en && !r_q[0]),
		.waddr (c_q),
		.wdata (in_data.sample),
		.raddr (raddr),
		.rdata (rd_even)
	);

	bayer_dm_ram #(
		.WIDTH (8),
		.DEPTH (MAX_WIDTH)
	) u_line_odd (
		.clk   (clk),
		.we    (cmd.wr_en && r_q[0]),
		.waddr (c_q),
		.wdata (in_data.sample),
		.raddr (raddr),
		.rdata (rd_odd)
	);

	assign same_d  = r_q[0] ? rd_odd : rd_even;
	assign other_d = r_q[0] ? rd_even : rd_odd;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sample_q <= in_data.sample;
		end
	end

	// 3x3 window, new column enters on the right
	always_comb begin
		case (cmd.win_op)
			WIN_SAMPLE: begin
				col_new[0] = same_d;
				col_new[1] = other_d;
				col_new[2] = sample_q;
			end
			WIN_DRAIN: begin
				col_new[0] = other_d;
				col_new[1] = same_d;
				col_new[2] = 8'd0;
			end
			default: begin
				col_new[0] = 8'd0;
				col_new[1] = 8'd0;
				col_new[2] = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.win_op != WIN_HOLD) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
				win_q[r][2] <= col_new[r];
			end
		end
	end

	// centre position and extent of the pixel being formed
	always_comb begin
		case (cmd.mode)
			PIX_SAMP1: begin
				pr   = r_q - 1'b1;
				pc   = c_q - 1'b1;
				rows = h_q;
			end
			PIX_SAMP2: begin
				pr   = r_q - 1'b1;
				pc   = c_q;
				rows = h_q;
			end
			PIX_DRAIN: begin
				pr   = r_q;
				pc   = dc_q;
				rows = SHW'(r_q) + 1'b1;
			end
			default: begin
				pr   = r_q;
				pc   = c_q;
				rows = h_q;
			end
		endcase
	end

	assign prx   = HX'(pr);
	assign pcx   = WX'(pc);
	assign rv[0] = (pr != '0) && ((prx - 1'b1) < HX'(rows));
	assign rv[1] = prx < HX'(rows);
	assign rv[2] = (prx + 1'b1) < HX'(rows);
	assign cv[0] = (pc != '0) && ((pcx - 1'b1) < WX'(w_q));
	assign cv[1] = pcx < WX'(w_q);
	assign cv[2] = (pcx + 1'b1) < WX'(w_q);
	assign own   = site_colour(pr[0], pc[0]);

	// per-colour sums and counts over in-frame window positions
	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		cnt_r = '0;
		cnt_g = '0;
		cnt_b = '0;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				if (rv[r] && cv[k]) begin
					case (site_colour(pr[0] ^ (r != 1), pc[0] ^ (k != 1)))
						CLR_RED: begin
							sum_r = sum_r + 11'(win_q[r][k]);
							cnt_r = cnt_r + 3'd1;
						end
						CLR_GREEN: begin
							sum_g = sum_g + 11'(win_q[r][k]);
							cnt_g = cnt_g + 3'd1;
						end
						CLR_BLUE: begin
							sum_b = sum_b + 11'(win_q[r][k]);
							cnt_b = cnt_b + 3'd1;
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			sum_r_s1 <= sum_r;
			sum_g_s1 <= sum_g;
			sum_b_s1 <= sum_b;
			cnt_r_s1 <= cnt_r;
			cnt_g_s1 <= cnt_g;
			cnt_b_s1 <= cnt_b;
			own_s1   <= own;
			ctr_s1   <= win_q[1][1];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.red       <= (own_s1 == CLR_RED)   ? ctr_s1 : mean_of(sum_r_s1, cnt_r_s1);
			out_q.green     <= (own_s1 == CLR_GREEN) ? ctr_s1 : mean_of(sum_g_s1, cnt_g_s1);
			out_q.blue      <= (own_s1 == CLR_BLUE)  ? ctr_s1 : mean_of(sum_b_s1, cnt_b_s1);
			out_q.frame_end <= (cmd.mode == PIX_DRAIN) && drain_last;
			out_q.run_last  <= cmd.run_last;
		end
	end

	assign out_data = out_q;

endmodule

// ===== rtl/core/bayer_dm_ctrl.sv =====
// controller: transfer handshakes and the per-item step sequence
module bayer_dm_ctrl import bayer_dm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     req_type,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_DR0,
		S_DR1,
		S_DR2,
		S_SUM,
		S_LOAD
	} state_t;

	state_t    state_q;
	state_t    state_d;
	pix_mode_t mode_q;
	pix_mode_t mode_d;
	logic      in_ready_q;
	logic      out_valid_q;
	logic      take;

	assign take = in_valid && in_ready_q;

	always_comb begin
		cmd      = '0;
		cmd.mode = mode_q;
		state_d  = state_q;
		mode_d   = mode_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.rd_sel = stat.draining ? RD_DC_M1 : RD_COL;
				cmd.take   = take;
				if (take) begin
					if (req_type == REQ_DRAIN) begin
						if (stat.draining) begin
							state_d = S_DR0;
							mode_d  = PIX_DRAIN;
						end
					end else if (req_type == REQ_SAMPLE && !stat.draining) begin
						cmd.wr_en = 1'b1;
						state_d   = S_SHIFT;
						mode_d    = PIX_SAMP1;
					end
				end
			end
			S_SHIFT: begin
				cmd.win_op = WIN_SAMPLE;
				if (stat.pix1) begin
					state_d = S_SUM;
				end else begin
					cmd.adv_samp = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_DR0: begin
				cmd.win_op = WIN_DRAIN;
				cmd.rd_sel = RD_DC_0;
				state_d    = S_DR1;
			end
			S_DR1: begin
				cmd.win_op = WIN_DRAIN;
				cmd.rd_sel = RD_DC_P1;
				state_d    = S_DR2;
			end
			S_DR2: begin
				cmd.win_op = WIN_DRAIN;
				state_d    = S_SUM;
			end
			S_SUM: begin
				cmd.calc = 1'b1;
				// row end: slide in an empty column for the last pixel of the row
				if (mode_q == PIX_SAMP1 && stat.pix2) begin
					cmd.win_op = WIN_ZERO;
				end
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					if (mode_q == PIX_SAMP1 && stat.pix2) begin
						mode_d  = PIX_SAMP2;
						state_d = S_SUM;
					end else begin
						cmd.run_last  = 1'b1;
						cmd.adv_samp  = (mode_q != PIX_DRAIN);
						cmd.adv_drain = (mode_q == PIX_DRAIN);
						state_d       = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= PIX_SAMP1;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			in_ready_q <= (state_d == S_IDLE);
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready_q |-> state_q == S_IDLE)
		else $error("input ready outside idle");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten before transfer");

	a_write_sample: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (cmd.take && !stat.draining))
		else $error("line memory written outside a sample transfer");

	a_drain_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DR2 |=> (state_q == S_SUM && mode_q == PIX_DRAIN))
		else $error("drain window fill not followed by drain pixel");
`endif

endmodule

// ===== sim/demosaic_checker.sv =====
// checker for the gbrg demosaic: watches all three channels, predicts each rgb pixel, compares
module demosaic_checker import bayer_dm_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fails,
	output int                    pending
);

	typedef enum int {
		CH_RED   = 0,
		CH_GREEN = 1,
		CH_BLUE  = 2
	} chan_t;

	typedef logic [8:0][7:0] patch_t;

	logic [7:0]            line_mem [2*MAX_WIDTH];
	patch_t                win;
	int unsigned           row_pos;
	int unsigned           col_pos;
	int unsigned           drain_pos;
	bit                    drain_on;
	logic [CFG_DATA_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0] height_reg;
	out_item_t             due_pixels [$];
	int                    err_cnt = 0;
	int                    due_cnt = 0;

	assign fails   = err_cnt;
	assign pending = due_cnt;

	function automatic int unsigned clamp_size(logic [CFG_DATA_W-1:0] v, int unsigned hi);
		if (v < SIZE_MIN) return SIZE_MIN;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic chan_t site_of(int unsigned r, int unsigned c);
		if (r % 2 == 0) return (c % 2 == 0) ? CH_GREEN : CH_BLUE;
		return (c % 2 == 0) ? CH_RED : CH_GREEN;
	endfunction

	function automatic logic [7:0] line_rd(int unsigned slot, int unsigned col);
		if (col >= MAX_WIDTH) return 8'h00;
		return line_mem[(slot % 2) * MAX_WIDTH + col];
	endfunction

	// nb holds rows pr-1..pr+1 by columns pc-1..pc+1, row-major
	function automatic out_item_t interpolate(patch_t nb, int unsigned pr, int unsigned pc,
			int unsigned rows, int unsigned cols);
		int unsigned sum [3];
		int unsigned cnt [3];
		logic [7:0]  comp [3];
		int unsigned rr;
		int unsigned cc;
		chan_t       own;
		chan_t       cl;
		out_item_t   px;
		for (int i = 0; i < 3; i++) begin
			sum[i] = 0;
			cnt[i] = 0;
		end
		for (int unsigned r = 0; r < 3; r++) begin
			rr = pr + r - 1;
			if ((r != 0 || pr != 0) && rr < rows) begin
				for (int unsigned k = 0; k < 3; k++) begin
					cc = pc + k - 1;
					if ((k != 0 || pc != 0) && cc < cols) begin
						cl = site_of(rr, cc);
						sum[cl] += nb[r*3+k];
						cnt[cl]++;
					end
				end
			end
		end
		own = site_of(pr, pc);
		for (int i = 0; i < 3; i++) begin
			if (i == own) comp[i] = nb[4];
			else if (cnt[i] == 0) comp[i] = 8'h00;
			else comp[i] = sum[i] / cnt[i];
		end
		px.red       = comp[CH_RED];
		px.green     = comp[CH_GREEN];
		px.blue      = comp[CH_BLUE];
		px.frame_end = 1'b0;
		px.run_last  = 1'b0;
		return px;
	endfunction

	task automatic clear_state();
		for (int i = 0; i < 2*MAX_WIDTH; i++) line_mem[i] = 8'h00;
		win        = '0;
		row_pos    = 0;
		col_pos    = 0;
		drain_pos  = 0;
		drain_on   = 1'b0;
		width_reg  = FRAME_WIDTH_RST;
		height_reg = FRAME_HEIGHT_RST;
		due_pixels.delete();
	endtask

	task automatic take_drain();
		int unsigned w;
		int unsigned c;
		patch_t      t;
		out_item_t   px;
		if (!drain_on) return;
		w = clamp_size(width_reg, MAX_WIDTH);
		c = drain_pos;
		t = '0;
		// top row is the row above the last one, middle row the last one, bottom outside
		t[0] = (c == 0) ? 8'h00 : line_rd(row_pos + 1, c - 1);
		t[1] = line_rd(row_pos + 1, c);
		t[2] = line_rd(row_pos + 1, c + 1);
		t[3] = (c == 0) ? 8'h00 : line_rd(row_pos, c - 1);
		t[4] = line_rd(row_pos, c);
		t[5] = line_rd(row_pos, c + 1);
		px = interpolate(t, row_pos, c, row_pos + 1, w);
		px.run_last = 1'b1;
		if (c >= w - 1) begin
			px.frame_end = 1'b1;
			drain_on     = 1'b0;
			drain_pos    = 0;
			row_pos      = 0;
			col_pos      = 0;
		end else begin
			drain_pos = c + 1;
		end
		due_pixels.push_back(px);
	endtask

	task automatic take_sample(logic [7:0] s);
		int unsigned w;
		int unsigned h;
		int unsigned r0;
		int unsigned c0;
		logic [7:0]  up2;
		logic [7:0]  up1;
		patch_t      tail_nb;
		out_item_t   p1;
		out_item_t   p2;
		bit          got1;
		bit          got2;
		if (drain_on) return;
		w   = clamp_size(width_reg, MAX_WIDTH);
		h   = clamp_size(height_reg, MAX_HEIGHT);
		r0  = row_pos;
		c0  = col_pos;
		up2 = line_rd(r0, c0);
		up1 = line_rd(r0 + 1, c0);
		for (int r = 0; r < 3; r++) begin
			win[r*3]   = win[r*3+1];
			win[r*3+1] = win[r*3+2];
		end
		win[2] = up2;
		win[5] = up1;
		win[8] = s;
		if (c0 < MAX_WIDTH) line_mem[(r0 % 2) * MAX_WIDTH + c0] = s;
		got1 = (r0 >= 1 && c0 >= 1);
		got2 = (r0 >= 1 && c0 >= w - 1);
		if (got1) begin
			p1 = interpolate(win, r0 - 1, c0 - 1, h, w);
			p1.run_last = !got2;
			due_pixels.push_back(p1);
		end
		if (got2) begin
			tail_nb = '0;
			for (int r = 0; r < 3; r++) begin
				tail_nb[r*3]   = win[r*3+1];
				tail_nb[r*3+1] = win[r*3+2];
			end
			p2 = interpolate(tail_nb, r0 - 1, c0, h, w);
			p2.run_last = 1'b1;
			due_pixels.push_back(p2);
		end
		if (c0 >= w - 1) begin
			col_pos = 0;
			if (r0 >= h - 1) begin
				drain_on  = 1'b1;
				drain_pos = 0;
			end else begin
				row_pos = r0 + 1;
			end
		end else begin
			col_pos = c0 + 1;
		end
	endtask

	task automatic report_bad(string what, logic [31:0] got, logic [31:0] want);
		err_cnt++;
		$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	task automatic check_pixel(out_item_t px);
		out_item_t want;
		if (due_pixels.size() == 0) begin
			report_bad("pixel with none outstanding", px, 0);
			return;
		end
		want = due_pixels.pop_front();
		if (px.red !== want.red) report_bad("red", px.red, want.red);
		if (px.green !== want.green) report_bad("green", px.green, want.green);
		if (px.blue !== want.blue) report_bad("blue", px.blue, want.blue);
		if (px.frame_end !== want.frame_end) report_bad("frame_end", px.frame_end, want.frame_end);
		if (px.run_last !== want.run_last) report_bad("run_last", px.run_last, want.run_last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_FRAME_WIDTH) width_reg = cfg_data;
				else if (cfg_index == CFG_FRAME_HEIGHT) height_reg = cfg_data;
			end
			if (in_valid && in_ready) begin
				if (in_data.req_type == REQ_DRAIN) take_drain();
				else take_sample(in_data.sample);
			end
			if (out_valid && out_ready) check_pixel(out_data);
		end
		due_cnt = due_pixels.size();
	end

endmodule

// ===== sim/tb_top.sv =====
// testbench top for the gbrg demosaic: bayer frames, drain steps and size writes, then the verdict
module tb_top;
	import bayer_dm_pkg::*;

	typedef enum int {
		FILL_RANDOM,
		FILL_HIGH,
		FILL_LOW,
		FILL_EXTREME
	} fill_t;

	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fails;
	int                    pending;

	int tx_idle_pct;
	int rx_stall_pct;
	int hold_left;
	int cur_w;
	int cur_h;
	bit hold_req;

	bayer_gbrg_bilinear_demosaic DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	demosaic_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fails(fails),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

	// pixel sink: random stalls, plus a long hold-off on request
	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic put_item(input logic req, input logic [7:0] smp);
		@(negedge clk);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid         <= 1'b1;
		in_data.req_type <= req;
		in_data.sample   <= smp;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering, let every due pixel out, then give the block time to go idle
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_size(input int w, input int h);
		write_reg(CFG_FRAME_WIDTH, (w == 2 && $urandom_range(1) == 1) ? $urandom_range(1) : w);
		write_reg(CFG_FRAME_HEIGHT, (h == 2 && $urandom_range(1) == 1) ? $urandom_range(1) : h);
		cur_w = w;
		cur_h = h;
	endtask

	function automatic logic [7:0] pick_sample(fill_t pat);
		case (pat)
			FILL_HIGH: return 8'hFF;
			FILL_LOW: return 8'h00;
			FILL_EXTREME: return ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
			default: return $urandom_range(255);
		endcase
	endfunction

	// a whole frame with a sprinkling of items that the block should ignore
	task automatic send_frame(input int w, input int h, input fill_t pat);
		for (int i = 0; i < w * h; i++) begin
			if ($urandom_range(99) < 3) put_item(REQ_DRAIN, $urandom_range(255));
			put_item(REQ_SAMPLE, pick_sample(pat));
		end
		for (int i = 0; i < w; i++) begin
			if ($urandom_range(99) < 3) put_item(REQ_SAMPLE, $urandom_range(255));
			put_item(REQ_DRAIN, $urandom_range(255));
		end
		if ($urandom_range(99) < 5) put_item(REQ_DRAIN, $urandom_range(255));
	endtask

	task automatic random_phase(input int tx, input int rx, input bit squeeze);
		int done;
		int w;
		int h;
		bit big;
		settle();
		tx_idle_pct  = tx;
		rx_stall_pct = rx;
		if (squeeze) begin
			set_size(20, 3);
			hold_req = 1'b1;
			send_frame(20, 3, FILL_RANDOM);
			settle();
		end
		done = 0;
		while (done < 40) begin
			big = ($urandom_range(9) == 0);
			if (big || $urandom_range(1) == 0) begin
				w = big ? $urandom_range(13, 32) : $urandom_range(2, 12);
				if (big) h = $urandom_range(2, 3);
				else if ($urandom_range(7) == 0) h = $urandom_range(7, 12);
				else h = $urandom_range(2, 6);
				settle();
				set_size(w, h);
			end
			send_frame(cur_w, cur_h,
				($urandom_range(3) == 0) ? fill_t'($urandom_range(1, 3)) : FILL_RANDOM);
			done += cur_w * cur_h + cur_w;
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_FRAME_WIDTH;
		cfg_data     = '0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_req     = 1'b0;
		cur_w        = FRAME_WIDTH_RST;
		cur_h        = FRAME_HEIGHT_RST;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// smallest frame, sizes below range, spare index, stray items on both sides
		write_reg(CFG_FRAME_WIDTH, 1);
		write_reg(CFG_FRAME_HEIGHT, 0);
		write_reg(CFG_SPARE, 13'h1FFF);
		put_item(REQ_DRAIN, 8'h5A);
		put_item(REQ_SAMPLE, 8'hFF);
		put_item(REQ_SAMPLE, 8'h00);
		put_item(REQ_SAMPLE, 8'h00);
		put_item(REQ_SAMPLE, 8'hFF);
		put_item(REQ_SAMPLE, 8'hA5);
		put_item(REQ_DRAIN, 8'h00);
		put_item(REQ_DRAIN, 8'hFF);
		put_item(REQ_DRAIN, 8'h3C);
		settle();

		// 3 x 4 frame: edge counts of three and a full count of four
		write_reg(CFG_FRAME_WIDTH, 3);
		write_reg(CFG_FRAME_HEIGHT, 4);
		for (int i = 0; i < 12; i++) put_item(REQ_SAMPLE, (i % 5 == 2) ? 8'h00 : 8'hFF);
		for (int i = 0; i < 3; i++) put_item(REQ_DRAIN, 8'h00);
		cur_w = 3;
		cur_h = 4;

		random_phase(0, 0, 1'b1);
		random_phase(88, 0, 1'b0);
		random_phase(0, 88, 1'b0);
		random_phase(31, 31, 1'b0);

		settle();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;

		// height saturated high, then cut down mid-frame
		write_reg(CFG_FRAME_WIDTH, 1);
		write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
		for (int i = 0; i < 6; i++) put_item(REQ_SAMPLE, $urandom_range(255));
		settle();
		write_reg(CFG_FRAME_HEIGHT, 2);
		for (int i = 0; i < 2; i++) put_item(REQ_SAMPLE, $urandom_range(255));
		for (int i = 0; i < 2; i++) put_item(REQ_DRAIN, $urandom_range(255));
		settle();

		// width saturated high, then cut down in the middle of the first row
		write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
		write_reg(CFG_FRAME_HEIGHT, 2);
		for (int i = 0; i < 10; i++) put_item(REQ_SAMPLE, $urandom_range(255));
		settle();
		write_reg(CFG_FRAME_WIDTH, 4);
		for (int i = 0; i < 5; i++) put_item(REQ_SAMPLE, $urandom_range(255));
		for (int i = 0; i < 4; i++) put_item(REQ_DRAIN, $urandom_range(255));

		settle();
		if (fails == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
